FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the jump distance block. Every user module has
// clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle
`define TJD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition implies a consequence in the next cycle
`define TJD_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

FILE: hw/rtl/tjd_pkg.sv
// ---------------------------------------------------------------------------
// tjd_pkg
// Shared widths for the jump distance block.
// ---------------------------------------------------------------------------
package tjd_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int TRACE_BITS_DEF = 16;
    localparam int STATE_BITS_DEF = 4;

endpackage

FILE: hw/rtl/track_jump_distance.sv
// ---------------------------------------------------------------------------
// track_jump_distance
// Jump length between consecutive molecules of the same trace: front stage
// for differences, squares and their sum, then a chain of square root cells.
// ---------------------------------------------------------------------------
//  channel   dir  tdata fields (low bit up)                 pad to
//  s_axis    in   trace_id, pos_x, pos_y, mol_state         bytes
//  m_axis    out  jump_trace, jump_length, jump_state       bytes
//
//  One molecule per cycle unless the output holds an item not taken; a jump
//  passes difference, square and sum registers, then one cell per root bit.
//  Molecules that start a trace update the previous position and emit nothing.
//  Reset clears the previous-molecule flag and all stage valids.
//  The whole pipeline stalls only while the output holds an item not taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module track_jump_distance #(
    parameter int COORD_BITS = tjd_pkg::COORD_BITS_DEF,
    parameter int TRACE_BITS = tjd_pkg::TRACE_BITS_DEF,
    parameter int STATE_BITS = tjd_pkg::STATE_BITS_DEF,
    localparam int IN_W  = ((TRACE_BITS + 2*COORD_BITS + STATE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((TRACE_BITS + COORD_BITS + 1 + STATE_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // trace_id, pos_x, pos_y, mol_state
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // jump_trace, jump_length, jump_state
);
    import tjd_pkg::*;

    localparam int C = COORD_BITS;
    localparam int N = COORD_BITS + 1;

    logic                   adv;
    logic [TRACE_BITS-1:0]  in_trace;
    logic [C-1:0]           in_x;
    logic [C-1:0]           in_y;
    logic [STATE_BITS-1:0]  in_state;
    logic [2*C:0]           sum;

    logic                   c_valid [0:N];
    logic [2*N-1:0]         c_rad   [0:N];
    logic [N:0]             c_rem   [0:N];
    logic [N-1:0]           c_root  [0:N];
    logic [TRACE_BITS-1:0]  c_trace [0:N];
    logic [STATE_BITS-1:0]  c_state [0:N];

    assign in_trace = s_tdata[TRACE_BITS-1:0];
    assign in_x     = s_tdata[TRACE_BITS +: C];
    assign in_y     = s_tdata[TRACE_BITS+C +: C];
    assign in_state = s_tdata[TRACE_BITS+2*C +: STATE_BITS];

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    tjd_front #(
        .COORD_BITS (COORD_BITS),
        .TRACE_BITS (TRACE_BITS),
        .STATE_BITS (STATE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_trace  (in_trace),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_state  (in_state),
        .out_valid (c_valid[0]),
        .out_trace (c_trace[0]),
        .out_state (c_state[0]),
        .out_sum   (sum)
    );

    assign c_rad[0]  = {1'b0, sum};
    assign c_rem[0]  = '0;
    assign c_root[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        tjd_sqrt_cell #(
            .ROOT_BITS  (N),
            .TRACE_BITS (TRACE_BITS),
            .STATE_BITS (STATE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (c_valid[i]),
            .in_rad    (c_rad[i]),
            .in_rem    (c_rem[i]),
            .in_root   (c_root[i]),
            .in_trace  (c_trace[i]),
            .in_state  (c_state[i]),
            .out_valid (c_valid[i+1]),
            .out_rad   (c_rad[i+1]),
            .out_rem   (c_rem[i+1]),
            .out_root  (c_root[i+1]),
            .out_trace (c_trace[i+1]),
            .out_state (c_state[i+1])
        );
    end

    assign m_tvalid = c_valid[N];
    assign m_tdata  = OUT_W'({c_state[N], c_root[N], c_trace[N]});

    `TJD_ASSERT(a_stall_only_when_full, s_tready || m_tvalid, "input stalled with empty output")

endmodule

FILE: hw/rtl/tjd_front.sv
// ---------------------------------------------------------------------------
// tjd_front
// Trace match against the previous molecule, absolute differences, squares
// and their sum, three register stages.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tjd_front #(
    parameter int COORD_BITS = 24,
    parameter int TRACE_BITS = 16,
    parameter int STATE_BITS = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic [TRACE_BITS-1:0]   in_trace,
    input  logic [COORD_BITS-1:0]   in_x,
    input  logic [COORD_BITS-1:0]   in_y,
    input  logic [STATE_BITS-1:0]   in_state,
    output logic                    out_valid,
    output logic [TRACE_BITS-1:0]   out_trace,
    output logic [STATE_BITS-1:0]   out_state,
    output logic [2*COORD_BITS:0]   out_sum
);
    import tjd_pkg::*;

    localparam int C = COORD_BITS;

    logic                   accept;
    logic                   match;
    logic [C-1:0]           dx;
    logic [C-1:0]           dy;
    logic [2*C-1:0]         dx_sq;
    logic [2*C-1:0]         dy_sq;

    logic                   have_prev_reg;
    logic [TRACE_BITS-1:0]  prev_trace_reg;
    logic [C-1:0]           prev_x_reg;
    logic [C-1:0]           prev_y_reg;

    logic                   a_valid_reg;
    logic [TRACE_BITS-1:0]  a_trace_reg;
    logic [STATE_BITS-1:0]  a_state_reg;
    logic [C-1:0]           a_dx_reg;
    logic [C-1:0]           a_dy_reg;

    logic                   b_valid_reg;
    logic [TRACE_BITS-1:0]  b_trace_reg;
    logic [STATE_BITS-1:0]  b_state_reg;
    logic [2*C-1:0]         b_dx_sq_reg;
    logic [2*C-1:0]         b_dy_sq_reg;

    logic                   c_valid_reg;
    logic [TRACE_BITS-1:0]  c_trace_reg;
    logic [STATE_BITS-1:0]  c_state_reg;
    logic [2*C:0]           c_sum_reg;

    assign accept = in_valid && adv;
    assign match  = have_prev_reg && (in_trace == prev_trace_reg);
    assign dx     = (in_x >= prev_x_reg) ? (in_x - prev_x_reg) : (prev_x_reg - in_x);
    assign dy     = (in_y >= prev_y_reg) ? (in_y - prev_y_reg) : (prev_y_reg - in_y);
    assign dx_sq  = a_dx_reg * a_dx_reg;
    assign dy_sq  = a_dy_reg * a_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg  <= 1'b0;
            prev_trace_reg <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                have_prev_reg  <= 1'b1;
                prev_trace_reg <= in_trace;
                prev_x_reg     <= in_x;
                prev_y_reg     <= in_y;
            end
            if (adv)
            begin
                a_valid_reg <= accept && match;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_trace_reg <= in_trace;
            a_state_reg <= in_state;
            a_dx_reg    <= dx;
            a_dy_reg    <= dy;
            b_trace_reg <= a_trace_reg;
            b_state_reg <= a_state_reg;
            b_dx_sq_reg <= dx_sq;
            b_dy_sq_reg <= dy_sq;
            c_trace_reg <= b_trace_reg;
            c_state_reg <= b_state_reg;
            c_sum_reg   <= {1'b0, b_dx_sq_reg} + {1'b0, b_dy_sq_reg};
        end
    end

    assign out_valid = c_valid_reg;
    assign out_trace = c_trace_reg;
    assign out_state = c_state_reg;
    assign out_sum   = c_sum_reg;

    `TJD_ASSERT_NEXT(a_prev_after_accept, accept, have_prev_reg, "no previous after accept")
    `TJD_ASSERT(a_jump_needs_prev, !a_valid_reg || have_prev_reg, "jump without previous")

endmodule

FILE: hw/rtl/tjd_sqrt_cell.sv
// ---------------------------------------------------------------------------
// tjd_sqrt_cell
// One restoring square root step: takes the next two radicand bits and
// settles one root bit, then hands everything to the next cell.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tjd_sqrt_cell #(
    parameter int ROOT_BITS  = 25,
    parameter int TRACE_BITS = 16,
    parameter int STATE_BITS = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic [2*ROOT_BITS-1:0]  in_rad,
    input  logic [ROOT_BITS:0]      in_rem,
    input  logic [ROOT_BITS-1:0]    in_root,
    input  logic [TRACE_BITS-1:0]   in_trace,
    input  logic [STATE_BITS-1:0]   in_state,
    output logic                    out_valid,
    output logic [2*ROOT_BITS-1:0]  out_rad,
    output logic [ROOT_BITS:0]      out_rem,
    output logic [ROOT_BITS-1:0]    out_root,
    output logic [TRACE_BITS-1:0]   out_trace,
    output logic [STATE_BITS-1:0]   out_state
);
    import tjd_pkg::*;

    localparam int R = ROOT_BITS;

    logic [R+2:0]           cur;
    logic [R+2:0]           trial;
    logic [R+2:0]           diff;
    logic                   ge;
    logic [R:0]             rem_next;
    logic [R-1:0]           root_next;

    logic                   valid_reg;
    logic [2*R-1:0]         rad_reg;
    logic [R:0]             rem_reg;
    logic [R-1:0]           root_reg;
    logic [TRACE_BITS-1:0]  trace_reg;
    logic [STATE_BITS-1:0]  state_reg;

    always_comb
    begin
        cur       = {in_rem, in_rad[2*R-1 -: 2]};
        trial     = {1'b0, in_root, 2'b01};
        diff      = cur - trial;
        ge        = (cur >= trial);
        rem_next  = ge ? diff[R:0] : cur[R:0];
        root_next = {in_root[R-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg   <= in_rad << 2;
            rem_reg   <= rem_next;
            root_reg  <= root_next;
            trace_reg <= in_trace;
            state_reg <= in_state;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_trace = trace_reg;
    assign out_state = state_reg;

    // partial remainder never exceeds twice the partial root
    `TJD_ASSERT(a_rem_bound, !valid_reg || (rem_reg <= ((R+1)'(root_reg) << 1)), "remainder out of range")

endmodule

FILE: dv/tb_track_jump_distance.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_track_jump_distance
// Streams molecules into the jump distance block and checks each jump item
// against a predictor that tracks the previous molecule and takes an exact
// integer square root. A directed run hits the first molecule, trace changes
// and extreme jumps. Random trace runs follow, with random gaps on both
// sides, one long output stall and pipeline drains.
// ---------------------------------------------------------------------------
module tb_track_jump_distance;

    localparam int CW    = tjd_pkg::COORD_BITS_DEF;
    localparam int TW    = tjd_pkg::TRACE_BITS_DEF;
    localparam int SW    = tjd_pkg::STATE_BITS_DEF;
    localparam int LW    = CW + 1;
    localparam int IN_W  = ((TW + 2*CW + SW + 7) / 8) * 8;
    localparam int OUT_W = ((TW + LW + SW + 7) / 8) * 8;

    localparam int X_LO  = TW;
    localparam int Y_LO  = TW + CW;
    localparam int MS_LO = TW + 2*CW;
    localparam int JL_LO = TW;
    localparam int JS_LO = TW + LW;

    localparam bit [CW-1:0] COORD_MAX = '1;
    localparam bit [TW-1:0] TRACE_MAX = '1;

    localparam int MOLECULES   = 1350;
    localparam int LONG_HOLD   = 400;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 64;

    typedef struct {
        bit [TW-1:0] trace;
        bit [LW-1:0] length;
        bit [SW-1:0] state;
    } jump_t;

    class jump_scoreboard;
        bit          have_prev;
        bit [TW-1:0] prev_trace;
        bit [CW-1:0] prev_x;
        bit [CW-1:0] prev_y;
        jump_t       pending_jumps[$];
        int          mismatches;
        int          molecules_noted;
        int          jumps_checked;
        int          zero_jumps;
        int          longest;

        function bit [LW-1:0] floor_sqrt(bit [63:0] v);
            bit [63:0] root;
            bit [63:0] trial;
            root = 0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v)
                    root = trial;
            end
            return root[LW-1:0];
        endfunction

        function void note_molecule(logic [IN_W-1:0] item);
            bit [TW-1:0] tr;
            bit [CW-1:0] x;
            bit [CW-1:0] y;
            bit [63:0]   dx;
            bit [63:0]   dy;
            jump_t       j;
            tr = item[0 +: TW];
            x  = item[X_LO +: CW];
            y  = item[Y_LO +: CW];
            molecules_noted++;
            if (have_prev && tr == prev_trace)
            begin
                dx = (x >= prev_x) ? x - prev_x : prev_x - x;
                dy = (y >= prev_y) ? y - prev_y : prev_y - y;
                j.trace  = tr;
                j.length = floor_sqrt(dx * dx + dy * dy);
                j.state  = item[MS_LO +: SW];
                pending_jumps.insert(pending_jumps.size(), j);
            end
            have_prev  = 1'b1;
            prev_trace = tr;
            prev_x     = x;
            prev_y     = y;
        endfunction

        function void check_jump(logic [OUT_W-1:0] item);
            logic [TW-1:0] got_trace;
            logic [LW-1:0] got_length;
            logic [SW-1:0] got_state;
            jump_t         want;
            got_trace  = item[0 +: TW];
            got_length = item[JL_LO +: LW];
            got_state  = item[JS_LO +: SW];
            if (pending_jumps.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected jump, expected none, actual %0d/%0d/%0d",
                         $time, got_trace, got_length, got_state);
                return;
            end
            want = pending_jumps.pop_front();
            jumps_checked++;
            if (want.length == 0)
                zero_jumps++;
            if (int'(want.length) > longest)
                longest = int'(want.length);
            if (got_trace !== want.trace)
            begin
                mismatches++;
                $display("%0t: jump_trace mismatch, expected %0d, actual %0d",
                         $time, want.trace, got_trace);
            end
            if (got_length !== want.length)
            begin
                mismatches++;
                $display("%0t: jump_length mismatch, expected %0d, actual %0d",
                         $time, want.length, got_length);
            end
            if (got_state !== want.state)
            begin
                mismatches++;
                $display("%0t: jump_state mismatch, expected %0d, actual %0d",
                         $time, want.state, got_state);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // trace_id, pos_x, pos_y, mol_state
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // jump_trace, jump_length, jump_state

    jump_scoreboard sb = new();
    int             sent;
    int             trace_runs;
    int             idle_cycles;
    bit             held_long;
    bit [TW-1:0]    cur_trace;
    bit [CW-1:0]    cur_x;
    bit [CW-1:0]    cur_y;

    track_jump_distance dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // handshake monitor and watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if (s_tvalid && s_tready)
                sb.note_molecule(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_jump(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function int send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function bit [CW-1:0] next_coord(bit [CW-1:0] prev);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return prev + CW'($urandom_range(0, 2047)) - CW'(1024);
        else if (r < 7)
            return prev + CW'($urandom_range(0, 1 << 19)) - CW'(1 << 18);
        else if (r < 9)
            return CW'($urandom);
        return $urandom_range(0, 1) ? COORD_MAX : '0;
    endfunction

    function bit [TW-1:0] next_trace(bit [TW-1:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return TW'($urandom);
        else if (r < 75)
            return prev + 1'b1;
        else if (r < 85)
            return prev - 1'b1;
        else if (r < 95)
            return $urandom_range(0, 1) ? TRACE_MAX : '0;
        return prev;
    endfunction

    task automatic send_molecule(input bit [TW-1:0] tr, input bit [CW-1:0] x,
                                 input bit [CW-1:0] y, input bit [SW-1:0] st,
                                 input int gap);
        logic [IN_W-1:0] item;
        item = '0;
        item[0 +: TW]     = tr;
        item[X_LO +: CW]  = x;
        item[Y_LO +: CW]  = y;
        item[MS_LO +: SW] = st;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    task automatic drain_jumps();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_jumps.size() != 0)
            @(posedge clk);
    endtask

    // output side: random back-pressure, one long hold-off
    initial
    begin
        int r;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held_long && sb.jumps_checked >= 300)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                held_long = 1'b1;
            end
            m_tready <= 1'b1;
            r = $urandom_range(0, 99);
            repeat (r < 70 ? $urandom_range(1, 8) : $urandom_range(20, 120)) @(posedge clk);
            m_tready <= 1'b0;
            r = $urandom_range(0, 99);
            if (r < 75)
                repeat ($urandom_range(1, 3)) @(posedge clk);
            else if (r < 95)
                repeat ($urandom_range(4, 15)) @(posedge clk);
            else
                repeat ($urandom_range(20, 60)) @(posedge clk);
        end
    end

    initial
    begin
        int  run_len;
        bit  no_gaps;
        bit  paused_mid;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // trace 0 matches the cleared previous trace but must still emit nothing
        send_molecule(16'd0,     24'd0,      24'd0,      4'd0,  send_gap());
        send_molecule(16'd0,     24'd0,      24'd0,      4'd15, send_gap());
        send_molecule(16'd0,     COORD_MAX,  COORD_MAX,  4'd5,  send_gap());
        send_molecule(16'd0,     24'd0,      24'd0,      4'd10, send_gap());
        send_molecule(16'd0,     COORD_MAX,  24'd0,      4'd3,  send_gap());
        send_molecule(16'd0,     24'd0,      COORD_MAX,  4'd12, send_gap());
        send_molecule(TRACE_MAX, 24'd100,    24'd200,    4'd1,  send_gap());
        send_molecule(TRACE_MAX, 24'd103,    24'd204,    4'd2,  send_gap());
        send_molecule(TRACE_MAX, 24'd103,    24'd204,    4'd15, send_gap());
        send_molecule(16'd4660,  24'd5,      24'd5,      4'd6,  send_gap());
        send_molecule(16'd4661,  24'd5,      24'd5,      4'd6,  send_gap());
        send_molecule(16'd4661,  24'hAAAAAA, 24'h555555, 4'd9,  send_gap());
        send_molecule(16'd4661,  24'h555555, 24'hAAAAAA, 4'd7,  send_gap());
        send_molecule(16'd4661,  24'd1,      24'd0,      4'd8,  send_gap());
        send_molecule(16'd4660,  24'd1,      24'd0,      4'd8,  send_gap());
        send_molecule(16'd4660,  24'd1,      24'd0,      4'd4,  send_gap());
        send_molecule(16'd0,     24'd7,      24'd7,      4'd0,  send_gap());
        send_molecule(16'd0,     24'd7,      24'd8,      4'd0,  send_gap());
        send_molecule(16'd0,     24'd8,      24'd7,      4'd14, send_gap());
        drain_jumps();

        cur_trace  = 16'd0;
        cur_x      = 24'd8;
        cur_y      = 24'd7;
        paused_mid = 1'b0;
        while (sent < MOLECULES)
        begin
            cur_trace = next_trace(cur_trace);
            run_len   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2)
                                                    : $urandom_range(2, 24);
            no_gaps   = ($urandom_range(0, 3) == 0);
            trace_runs++;
            for (int i = 0; i < run_len; i++)
            begin
                cur_x = next_coord(cur_x);
                cur_y = next_coord(cur_y);
                send_molecule(cur_trace, cur_x, cur_y, SW'($urandom),
                              no_gaps ? 0 : send_gap());
            end
            if (!paused_mid && sent >= MOLECULES / 2)
            begin
                drain_jumps();
                paused_mid = 1'b1;
            end
        end

        drain_jumps();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Covered %0d molecules in %0d random trace runs plus directed cases.",
                 sb.molecules_noted, trace_runs);
        $display("Checked %0d jumps (%0d of zero length, longest %0d), long output stall %0s.",
                 sb.jumps_checked, sb.zero_jumps, sb.longest, held_long ? "seen" : "missed");
        if (sb.mismatches == 0 && sb.pending_jumps.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/tjd_pkg.sv
hw/rtl/tjd_front.sv
hw/rtl/tjd_sqrt_cell.sv
hw/rtl/track_jump_distance.sv
dv/tb_track_jump_distance.sv
